>>> hw/rtl/greedy_change_breakdown_core_macros.svh
// Assertion macros shared by the change breakdown RTL.
`ifndef GREEDY_CHANGE_BREAKDOWN_CORE_MACROS_SVH
`define GREEDY_CHANGE_BREAKDOWN_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/gcb_pkg.sv
package gcb_pkg;

   // Field widths of the item and result channels.
   localparam int WholeWidth = 20;
   localparam int HundWidth  = 10;
   localparam int ValueWidth = 8;
   localparam int CountWidth = 13;

   // Denomination sequencing.
   localparam int NumDenoms = 14;
   localparam int IdxWidth  = 4;
   localparam logic [IdxWidth-1:0] IdxWhole200   = 4'd0;
   localparam logic [IdxWidth-1:0] IdxHund50     = 4'd8;
   localparam logic [IdxWidth-1:0] IdxLastDenom  = 4'(NumDenoms - 1);

   // Reciprocals for the two wide divisions: x / 200 = (x >> 3) / 25 and
   // h / 50 = (h >> 1) / 25. Both products are exact over the input range.
   localparam int WholeDivInWidth  = WholeWidth - 3;
   localparam int WholeRecipWidth  = 18;
   localparam int WholeRecipShift  = 22;
   localparam logic [WholeRecipWidth-1:0] WholeRecip = 18'd167773;
   localparam int WholeProdWidth   = WholeDivInWidth + WholeRecipWidth;

   localparam int HundDivInWidth   = HundWidth - 1;
   localparam int HundRecipWidth   = 10;
   localparam int HundRecipShift   = 14;
   localparam logic [HundRecipWidth-1:0] HundRecip = 10'd656;
   localparam int HundProdWidth    = HundDivInWidth + HundRecipWidth;
   localparam int HundQuotWidth    = 5;

   // Queue between the front and the back.
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CntWidth   = $clog2(QueueDepth + 1);

   // One classified item: both amounts and the estimated wide quotients.
   typedef struct packed {
      logic [WholeWidth-1:0]    whole;
      logic [HundWidth-1:0]     hund;
      logic [CountWidth-1:0]    q200;
      logic [HundQuotWidth-1:0] q50;
   } gcb_job_type;

   typedef struct packed {
      logic        valid;
      gcb_job_type job;
   } gcb_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } gcb_qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_FLUSH
   } gcb_back_state_type;

   // Face value of each denomination in emission order.
   function automatic logic [ValueWidth-1:0] denom_face(input logic [IdxWidth-1:0] idx);
      logic [ValueWidth-1:0] face;
      unique case (idx)
         4'd0:    face = 8'd200;
         4'd1:    face = 8'd100;
         4'd2:    face = 8'd50;
         4'd3:    face = 8'd20;
         4'd4:    face = 8'd10;
         4'd5:    face = 8'd5;
         4'd6:    face = 8'd2;
         4'd7:    face = 8'd1;
         4'd8:    face = 8'd50;
         4'd9:    face = 8'd20;
         4'd10:   face = 8'd10;
         4'd11:   face = 8'd5;
         4'd12:   face = 8'd2;
         4'd13:   face = 8'd1;
         default: face = 8'd1;
      endcase
      return face;
   endfunction

   // Hundredth denominations follow the whole-unit ones.
   function automatic logic denom_is_hund(input logic [IdxWidth-1:0] idx);
      return idx >= IdxHund50;
   endfunction

endpackage

>>> hw/rtl/gcb_front.sv
module gcb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gcb_pkg::WholeWidth-1:0]     req_whole_units,
   input  logic [gcb_pkg::HundWidth-1:0]      req_hundredths,
   input  gcb_pkg::gcb_qstat_type             qstat,
   output gcb_pkg::gcb_push_type              push
);
   import gcb_pkg::*;

   logic                       stage_valid_ff, stage_valid_in;
   gcb_job_type                stage_job_ff, stage_job_in;
   logic                       accept;
   logic                       move_out;
   logic [WholeProdWidth-1:0]  whole_prod;
   logic [HundProdWidth-1:0]   hund_prod;

   // The stage holds one item until the queue has room for it.
   assign move_out = stage_valid_ff && !qstat.full;
   assign busy     = stage_valid_ff && qstat.full;
   assign accept   = start && !busy;

   // Estimate the two wide quotients with reciprocal products.
   assign whole_prod = WholeProdWidth'(req_whole_units[WholeWidth-1:3]) *
                       WholeProdWidth'(WholeRecip);
   assign hund_prod  = HundProdWidth'(req_hundredths[HundWidth-1:1]) *
                       HundProdWidth'(HundRecip);

   always_comb begin
      stage_job_in.whole = req_whole_units;
      stage_job_in.hund  = req_hundredths;
      stage_job_in.q200  = whole_prod[WholeRecipShift +: CountWidth];
      stage_job_in.q50   = hund_prod[HundRecipShift +: HundQuotWidth];
      stage_valid_in     = accept || (stage_valid_ff && !move_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_job_ff <= stage_job_in;
      end
   end

   assign push.valid = move_out;
   assign push.job   = stage_job_ff;

endmodule

>>> hw/rtl/gcb_queue.sv
`include "greedy_change_breakdown_core_macros.svh"

module gcb_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  gcb_pkg::gcb_push_type   push,
   input  logic                    pop,
   output gcb_pkg::gcb_qstat_type  qstat,
   output gcb_pkg::gcb_job_type    head
);
   import gcb_pkg::*;

   gcb_job_type          entry_ff [QueueDepth];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push.valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   assign qstat.full  = (cnt_ff == CntWidth'(QueueDepth));
   assign qstat.empty = (cnt_ff == '0);
   assign head        = entry_ff[rd_ptr_ff];

   `GCB_ASSERT_NOW(a_no_push_full, clock, reset, push.valid, !qstat.full, "push into full queue")
   `GCB_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !qstat.empty, "pop from empty queue")
   `GCB_ASSERT_NEXT(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CntWidth'(QueueDepth),
      "queue count beyond depth")

endmodule

>>> hw/rtl/gcb_back.sv
`include "greedy_change_breakdown_core_macros.svh"

module gcb_back (
   input  logic                               clock,
   input  logic                               reset,
   input  gcb_pkg::gcb_qstat_type             qstat,
   input  gcb_pkg::gcb_job_type               head,
   output logic                               pop,
   output logic                               rsp_strobe,
   output logic [gcb_pkg::ValueWidth-1:0]     rsp_denom_value,
   output logic                               rsp_is_hundredths,
   output logic [gcb_pkg::CountWidth-1:0]     rsp_piece_count,
   output logic                               rsp_last
);
   import gcb_pkg::*;

   gcb_back_state_type        state_ff, state_in;
   logic [IdxWidth-1:0]       idx_ff, idx_in;
   logic [WholeWidth-1:0]     whole_ff, whole_in;
   logic [HundWidth-1:0]      hund_ff, hund_in;
   logic [CountWidth-1:0]     q200_ff, q200_in;
   logic [HundQuotWidth-1:0]  q50_ff, q50_in;

   logic                      pend_valid_ff, pend_valid_in;
   logic [ValueWidth-1:0]     pend_value_ff, pend_value_in;
   logic                      pend_hund_ff, pend_hund_in;
   logic [CountWidth-1:0]     pend_count_ff, pend_count_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [ValueWidth-1:0]     rsp_value_ff, rsp_value_in;
   logic                      rsp_hund_ff, rsp_hund_in;
   logic [CountWidth-1:0]     rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [ValueWidth-1:0]     face;
   logic                      is_hund;
   logic [WholeWidth-1:0]     prod200, rem200;
   logic [HundWidth-1:0]      prod50, rem50;
   logic [ValueWidth-1:0]     small_rem, small_next;
   logic [ValueWidth:0]       twice_face;
   logic [CountWidth-1:0]     step_count;
   logic [WholeWidth-1:0]     whole_next;
   logic [HundWidth-1:0]      hund_next;

   // One denomination step: the wide first steps correct the reciprocal
   // quotient, the narrow steps need at most two pieces.
   always_comb begin
      face       = denom_face(idx_ff);
      is_hund    = denom_is_hund(idx_ff);
      prod200    = (WholeWidth'(q200_ff) << 7) + (WholeWidth'(q200_ff) << 6) +
                   (WholeWidth'(q200_ff) << 3);
      rem200     = whole_ff - prod200;
      prod50     = (HundWidth'(q50_ff) << 5) + (HundWidth'(q50_ff) << 4) +
                   (HundWidth'(q50_ff) << 1);
      rem50      = hund_ff - prod50;
      small_rem  = is_hund ? hund_ff[ValueWidth-1:0] : whole_ff[ValueWidth-1:0];
      twice_face = {face, 1'b0};
      small_next = small_rem;
      step_count = '0;
      whole_next = whole_ff;
      hund_next  = hund_ff;
      if (idx_ff == IdxWhole200) begin
         if (rem200 >= WholeWidth'(200)) begin
            step_count = q200_ff + 1'b1;
            whole_next = rem200 - WholeWidth'(200);
         end else begin
            step_count = q200_ff;
            whole_next = rem200;
         end
      end else if (idx_ff == IdxHund50) begin
         if (rem50 >= HundWidth'(50)) begin
            step_count = CountWidth'(q50_ff) + 1'b1;
            hund_next  = rem50 - HundWidth'(50);
         end else begin
            step_count = CountWidth'(q50_ff);
            hund_next  = rem50;
         end
      end else begin
         if ({1'b0, small_rem} >= twice_face) begin
            step_count = CountWidth'(2);
            small_next = small_rem - twice_face[ValueWidth-1:0];
         end else if (small_rem >= face) begin
            step_count = CountWidth'(1);
            small_next = small_rem - face;
         end
         if (is_hund) begin
            hund_next = HundWidth'(small_next);
         end else begin
            whole_next = WholeWidth'(small_next);
         end
      end
   end

   // Sequencer: load an item, walk the fourteen denominations, then flush.
   // A found result is held back until the next found result or the flush, so that the last one is known.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      whole_in      = whole_ff;
      hund_in       = hund_ff;
      q200_in       = q200_ff;
      q50_in        = q50_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      pend_hund_in  = pend_hund_ff;
      pend_count_in = pend_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = pend_value_ff;
      rsp_hund_in   = pend_hund_ff;
      rsp_count_in  = pend_count_ff;
      rsp_last_in   = 1'b0;
      pop           = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               pop           = 1'b1;
               whole_in      = head.whole;
               hund_in       = head.hund;
               q200_in       = head.q200;
               q50_in        = head.q50;
               idx_in        = IdxWhole200;
               pend_valid_in = 1'b0;
               state_in      = BK_RUN;
            end
         end
         BK_RUN: begin
            whole_in = whole_next;
            hund_in  = hund_next;
            if (step_count != '0) begin
               rsp_strobe_in = pend_valid_ff;
               pend_valid_in = 1'b1;
               pend_value_in = face;
               pend_hund_in  = is_hund;
               pend_count_in = step_count;
            end
            if (idx_ff == IdxLastDenom) begin
               state_in = BK_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         BK_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            if (!pend_valid_ff) begin
               rsp_value_in = '0;
               rsp_hund_in  = 1'b0;
               rsp_count_in = '0;
            end
            pend_valid_in = 1'b0;
            state_in      = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      whole_ff      <= whole_in;
      hund_ff       <= hund_in;
      q200_ff       <= q200_in;
      q50_ff        <= q50_in;
      pend_value_ff <= pend_value_in;
      pend_hund_ff  <= pend_hund_in;
      pend_count_ff <= pend_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_hund_ff   <= rsp_hund_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_denom_value   = rsp_value_ff;
   assign rsp_is_hundredths = rsp_hund_ff;
   assign rsp_piece_count   = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   `GCB_ASSERT_NEXT(a_flush_emits, clock, reset, state_ff == BK_FLUSH,
      rsp_strobe_ff && rsp_last_ff, "flush did not emit the last result")
   `GCB_ASSERT_NOW(a_more_follows, clock, reset, rsp_strobe_ff && !rsp_last_ff,
      pend_valid_ff, "non-last result without a following result")
   `GCB_ASSERT_NOW(a_marker_form, clock, reset, rsp_strobe_ff && rsp_count_ff == '0,
      rsp_last_ff && rsp_value_ff == '0, "malformed empty marker")
   `GCB_ASSERT_NOW(a_idle_clean, clock, reset, state_ff == BK_IDLE, !pend_valid_ff,
      "pending result left in idle")

endmodule

>>> hw/rtl/greedy_change_breakdown_core.sv
// Channel   Ports                                   Handshake
// item      req_whole_units, req_hundredths         start high while busy is low
// result    rsp_denom_value, rsp_is_hundredths,     rsp_strobe for one cycle
//           rsp_piece_count, rsp_last
//
// An item is registered in the front stage, where the wide quotients are estimated
// by reciprocal products, then waits in a two-entry queue. The back sequencer
// works on one item at a time: one load, fourteen denomination steps and one
// flush that emits the last result, and it takes no new item before that flush.
// A result is held until the next used denomination or the flush. Reset is
// synchronous and empties all three parts. The receiver cannot stall; busy rises
// only when the front stage and queue fill.
module greedy_change_breakdown_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gcb_pkg::WholeWidth-1:0]     req_whole_units,
   input  logic [gcb_pkg::HundWidth-1:0]      req_hundredths,
   output logic                               rsp_strobe,
   output logic [gcb_pkg::ValueWidth-1:0]     rsp_denom_value,
   output logic                               rsp_is_hundredths,
   output logic [gcb_pkg::CountWidth-1:0]     rsp_piece_count,
   output logic                               rsp_last
);
   import gcb_pkg::*;

   gcb_push_type   push;
   gcb_qstat_type  qstat;
   gcb_job_type    head;
   logic           pop;

   gcb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_whole_units (req_whole_units),
      .req_hundredths  (req_hundredths),
      .qstat           (qstat),
      .push            (push)
   );

   gcb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .qstat (qstat),
      .head  (head)
   );

   gcb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .head              (head),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_denom_value   (rsp_denom_value),
      .rsp_is_hundredths (rsp_is_hundredths),
      .rsp_piece_count   (rsp_piece_count),
      .rsp_last          (rsp_last)
   );

endmodule
